### src/weighted_bray_curtis_distance_top_macros.svh
// Assertion macros for the weighted Bray-Curtis distance block.
// Used by the top level only; no other dependencies.
`ifndef WEIGHTED_BRAY_CURTIS_DISTANCE_TOP_MACROS_SVH
`define WEIGHTED_BRAY_CURTIS_DISTANCE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define WBCD_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define WBCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define WBCD_ASSERT(lbl, clk, rst_n, cond, msg)
`define WBCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/wbcd_pkg.sv
// Shared types and constants of the weighted Bray-Curtis distance block.
// No dependencies; used by every module of the block.
package wbcd_pkg;

    localparam int ACC_W   = 45;  // accumulator width
    localparam int NPROD_W = 32;  // w * |a-b|
    localparam int DPROD_W = 33;  // w * (a+b)
    localparam int Q_BITS  = 16;  // fraction bits of the distance
    localparam int CNT_W   = 4;   // counts Q_BITS division steps

    typedef struct packed {
        logic [15:0] count_a;
        logic [15:0] count_b;
        logic [15:0] feature_weight;
        logic        last_feature;
    } t_in_item;

    typedef struct packed {
        logic [15:0] distance;
        logic        zero_denominator;
    } t_out_item;

    typedef struct packed {
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### src/wbcd_front.sv
// Front end: accepts features, forms the two weighted products and accumulates them.
// Depends on wbcd_pkg; pushes finished sum pairs into wbcd_queue.
module wbcd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wbcd_pkg::t_in_item i_data,
    output logic              o_push,
    output wbcd_pkg::t_pair   o_pair,
    input  logic              i_full
);

    logic                          r_p_valid;
    logic                          r_p_last;
    logic [wbcd_pkg::NPROD_W-1:0]  r_p_num;
    logic [wbcd_pkg::DPROD_W-1:0]  r_p_den;
    logic [wbcd_pkg::ACC_W-1:0]    r_num_acc;
    logic [wbcd_pkg::ACC_W-1:0]    r_den_acc;

    logic                          w_stall;
    logic [15:0]                   w_diff;
    logic [16:0]                   w_sum;
    logic [wbcd_pkg::NPROD_W-1:0]  w_num_prod;
    logic [wbcd_pkg::DPROD_W-1:0]  w_den_prod;
    logic [wbcd_pkg::ACC_W:0]      w_num_next;
    logic [wbcd_pkg::ACC_W:0]      w_den_next;
    logic [wbcd_pkg::ACC_W-1:0]    w_num_sat;
    logic [wbcd_pkg::ACC_W-1:0]    w_den_sat;

    // The product stage holds only while a last feature waits for queue space.
    assign w_stall = r_p_valid && r_p_last && i_full;
    assign o_ready = !w_stall;

    assign w_diff = (i_data.count_a > i_data.count_b) ? (i_data.count_a - i_data.count_b)
                                                      : (i_data.count_b - i_data.count_a);
    assign w_sum  = {1'b0, i_data.count_a} + {1'b0, i_data.count_b};

    assign w_num_prod = {16'b0, i_data.feature_weight} * {16'b0, w_diff};
    assign w_den_prod = {17'b0, i_data.feature_weight} * {16'b0, w_sum};

    // The carry out of bit 44 is the only way past 2^45-1, so it selects the clamp.
    assign w_num_next = {1'b0, r_num_acc} + {{(wbcd_pkg::ACC_W+1-wbcd_pkg::NPROD_W){1'b0}}, r_p_num};
    assign w_den_next = {1'b0, r_den_acc} + {{(wbcd_pkg::ACC_W+1-wbcd_pkg::DPROD_W){1'b0}}, r_p_den};
    assign w_num_sat  = w_num_next[wbcd_pkg::ACC_W] ? '1 : w_num_next[wbcd_pkg::ACC_W-1:0];
    assign w_den_sat  = w_den_next[wbcd_pkg::ACC_W] ? '1 : w_den_next[wbcd_pkg::ACC_W-1:0];

    assign o_push     = r_p_valid && r_p_last && !i_full;
    assign o_pair.num = w_num_sat;
    assign o_pair.den = w_den_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_num_acc <= '0;
            r_den_acc <= '0;
        end else if (!w_stall) begin
            r_p_valid <= i_valid;
            if (r_p_valid) begin
                if (r_p_last) begin
                    r_num_acc <= '0;
                    r_den_acc <= '0;
                end else begin
                    r_num_acc <= w_num_sat;
                    r_den_acc <= w_den_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && i_valid) begin
            r_p_num  <= w_num_prod;
            r_p_den  <= w_den_prod;
            r_p_last <= i_data.last_feature;
        end
    end

endmodule

### src/wbcd_queue.sv
// Two-entry queue of finished numerator and denominator sums.
// Depends on wbcd_pkg; sits between wbcd_front and wbcd_back.
module wbcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wbcd_pkg::t_pair     i_pair,
    input  logic                i_pop,
    output wbcd_pkg::t_pair     o_pair,
    output wbcd_pkg::t_q_status o_status
);

    wbcd_pkg::t_pair r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_pair         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

endmodule

### src/wbcd_back.sv
// Back end: restoring divider, one quotient bit a cycle, and the output register.
// Depends on wbcd_pkg; takes sum pairs from wbcd_queue.
module wbcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbcd_pkg::t_pair     i_pair,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output wbcd_pkg::t_out_item o_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [wbcd_pkg::ACC_W:0]        r_rem;
    logic [wbcd_pkg::ACC_W-1:0]      r_den;
    logic [wbcd_pkg::Q_BITS-1:0]     r_quot;
    logic                            r_zero;
    logic [wbcd_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_out_valid;
    wbcd_pkg::t_out_item             r_out;

    logic [wbcd_pkg::ACC_W:0]        w_shift;
    logic                            w_ge;
    logic                            w_out_free;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || i_ready;

    // The remainder stays below the divisor, so it fits in ACC_W bits before the shift.
    assign w_shift = {r_rem[wbcd_pkg::ACC_W-1:0], 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is refilled by the state below instead.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_den <= i_pair.den;
                        r_rem <= {1'b0, i_pair.num};
                        r_cnt <= '0;
                        if (i_pair.den == '0) begin
                            r_quot  <= '0;
                            r_zero  <= 1'b1;
                            r_state <= S_DONE;
                        end else if (i_pair.num >= i_pair.den) begin
                            r_quot  <= '1;
                            r_zero  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_quot  <= '0;
                            r_zero  <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
                    r_quot <= {r_quot[wbcd_pkg::Q_BITS-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == wbcd_pkg::CNT_W'(wbcd_pkg::Q_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out.distance         <= r_quot;
                        r_out.zero_denominator <= r_zero;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/weighted_bray_curtis_distance_top.sv
// Top level of the weighted Bray-Curtis distance block.
// Depends on wbcd_pkg, wbcd_front, wbcd_queue, wbcd_back and the assertion macro header.
//
//   Channel   Direction  Handshake          Payload
//   features  in         i_valid / o_ready  i_data (t_in_item)
//   distance  out        o_valid / i_ready  o_data (t_out_item)
//
// The front end takes one feature transfer every cycle while o_ready is high. After the last
// feature, its sums pass from the product register through the queue to the divider, which
// loads the pair, forms the quotient bits (skipped for a zero denominator or a full-scale
// ratio), fills the output register and raises o_valid, and only then takes the next pair.
// Two finished pairs can wait in the queue; o_ready drops only when a last feature finds it
// full. Reset is synchronous and active low and clears sums and control.
`include "weighted_bray_curtis_distance_top_macros.svh"

module weighted_bray_curtis_distance_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wbcd_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output wbcd_pkg::t_out_item o_data
);

    // Sum pairs travel from the accumulators to the divider through this queue.
    logic                w_push;
    logic                w_pop;
    wbcd_pkg::t_pair     w_front_pair;
    wbcd_pkg::t_pair     w_queue_pair;
    wbcd_pkg::t_q_status w_q_status;

    wbcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (w_push),
        .o_pair  (w_front_pair),
        .i_full  (w_q_status.full)
    );

    wbcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pair   (w_front_pair),
        .i_pop    (w_pop),
        .o_pair   (w_queue_pair),
        .o_status (w_q_status)
    );

    // The divider takes a pair only when it is idle and the queue holds one.
    wbcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (w_queue_pair),
        .i_empty (w_q_status.empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    `WBCD_ASSERT(a_no_push_full, i_clk, i_rst_n, !(w_push && w_q_status.full), "push into full queue")
    `WBCD_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(w_pop && w_q_status.empty), "pop from empty queue")
    `WBCD_ASSERT_IMPL(a_zero_dist, i_clk, i_rst_n, o_valid && o_data.zero_denominator, o_data.distance == 16'd0, "nonzero distance with zero denominator")

endmodule
